// ----- src/patan_pkg.sv -----
//------------------------------------------------------------------------------
// patan_pkg: shared constants and types for the polynomial atan2 unit
// Fixed-point widths, polynomial coefficients and angle constants.
//------------------------------------------------------------------------------
package patan_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int MAG_WIDTH   = COORD_WIDTH + 1;
	localparam int QUO_WIDTH   = 17;
	localparam int ANGLE_WIDTH = 16;

	// Coefficients in Q4.16.
	localparam logic signed [19:0] C_A1  = 20'sd65535;
	localparam logic signed [19:0] C_A3  = -20'sd21799;
	localparam logic signed [19:0] C_A5  = 20'sd12684;
	localparam logic signed [19:0] C_A7  = -20'sd7631;
	localparam logic signed [19:0] C_A9  = 20'sd3451;
	localparam logic signed [19:0] C_A11 = -20'sd768;

	localparam logic signed [20:0] PI_Q16      = 21'sd205887;
	localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [17:0] ANGLE_MAX   = 18'sd25736;

	// Product shifted right by 16, rounding half up; result kept at 20 bits.
	function automatic logic signed [19:0] rshift16(input logic signed [39:0] v);
		logic signed [39:0] t;
		t = v + 40'sd32768;
		return t[35:16];
	endfunction

endpackage

// ----- src/polynomial_atan2_unit.sv -----
//------------------------------------------------------------------------------
// polynomial_atan2_unit: four-quadrant arctangent, pipelined
// Restoring division one quotient bit per stage, then Horner steps one per stage.
//------------------------------------------------------------------------------
// Throughput: one request per cycle; busy is held low, the pipe never stalls.
// The depth is set by the input stage, 17 division stages, the ratio stage,
// seven Horner stages, the quadrant stage and the output register.
// Reset clears all stage valid bits; payload registers are not reset.
module polynomial_atan2_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [patan_pkg::COORD_WIDTH-1:0] coord_y,
	input  logic signed [patan_pkg::COORD_WIDTH-1:0] coord_x,
	output logic        done,
	output logic signed [patan_pkg::ANGLE_WIDTH-1:0] angle
);

	localparam int CW = patan_pkg::COORD_WIDTH;
	localparam int MW = patan_pkg::MAG_WIDTH;
	localparam int ND = patan_pkg::QUO_WIDTH;
	localparam int AW = patan_pkg::ANGLE_WIDTH;

	typedef struct packed {
		logic swap;
		logic neg;
		logic xneg;
		logic yneg;
		logic zero;
	} flags_t;

	// Input capture and magnitude/swap decisions.
	logic         v_s1;
	logic [MW-1:0] an_s1, ad_s1;
	flags_t       f_s1;

	logic [MW-1:0] ay_c, ax_c;
	logic          swap_c;
	always_comb begin
		ay_c = coord_y[CW-1] ? MW'(-{coord_y[CW-1], coord_y}) : MW'({coord_y[CW-1], coord_y});
		ax_c = coord_x[CW-1] ? MW'(-{coord_x[CW-1], coord_x}) : MW'({coord_x[CW-1], coord_x});
		swap_c = ax_c < ay_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		an_s1     <= swap_c ? ax_c : ay_c;
		ad_s1     <= swap_c ? ay_c : ax_c;
		f_s1.swap <= swap_c;
		f_s1.neg  <= coord_x[CW-1] != coord_y[CW-1];
		f_s1.xneg <= coord_x[CW-1];
		f_s1.yneg <= coord_y[CW-1];
		f_s1.zero <= (ax_c == '0) && (ay_c == '0);
	end

	// Quotient divider: 17 restoring steps give (an << 16) / ad.
	// The remainder starts at an itself; later steps shift in zeros.
	logic          qv [ND+1];
	logic [MW:0]   qr [ND+1];
	logic [ND-1:0] qq [ND+1];
	logic [MW-1:0] qd [ND+1];
	flags_t        qf [ND+1];

	assign qv[0] = v_s1;
	assign qr[0] = {2'b00, an_s1[MW-1:1]};
	assign qq[0] = '0;
	assign qd[0] = ad_s1;
	assign qf[0] = f_s1;

	for (genvar k = 0; k < ND; k++) begin : g_qd
		logic [MW+1:0] tr;
		logic          nb;
		always_comb begin
			nb = (k == 0) ? an_s1[0] : 1'b0;
			tr = {qr[k], nb} - {2'b00, qd[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qv[k+1] <= 1'b0;
			end else begin
				qv[k+1] <= qv[k];
			end
		end
		always_ff @(posedge clk) begin
			qd[k+1] <= qd[k];
			qf[k+1] <= qf[k];
			if (!tr[MW+1]) begin
				qr[k+1] <= tr[MW:0];
				qq[k+1] <= {qq[k][ND-2:0], 1'b1};
			end else begin
				qr[k+1] <= {qr[k][MW-1:0], nb};
				qq[k+1] <= {qq[k][ND-2:0], 1'b0};
			end
		end
	end

	// Rounding, saturation and sign of the ratio; t = r * 2.
	logic [ND-1:0] qsum;
	logic [15:0]   qsat;
	logic signed [17:0] t_s;
	flags_t        f_t;
	logic          v_t;
	always_comb begin
		qsum = qq[ND] + ND'(1);
		qsat = (qsum[ND-1:1] > 16'd32767) ? 16'd32767 : qsum[ND-1:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t <= 1'b0;
		end else begin
			v_t <= qv[ND];
		end
	end

	always_ff @(posedge clk) begin
		f_t <= qf[ND];
		t_s <= qf[ND].neg ? -$signed({1'b0, qsat, 1'b0}) : $signed({1'b0, qsat, 1'b0});
	end

	// Horner chain: stage 0 squares t, stages 1..5 apply coefficients, 6 multiplies by t.
	logic               hv [8];
	logic signed [19:0] hs [5];
	logic signed [19:0] hp [7];
	logic signed [17:0] ht [6];
	flags_t             hf [7];

	logic signed [19:0] coef [5];
	assign coef[0] = patan_pkg::C_A9;
	assign coef[1] = patan_pkg::C_A7;
	assign coef[2] = patan_pkg::C_A5;
	assign coef[3] = patan_pkg::C_A3;
	assign coef[4] = patan_pkg::C_A1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv[0] <= 1'b0;
		end else begin
			hv[0] <= v_t;
		end
	end
	always_ff @(posedge clk) begin
		hs[0] <= patan_pkg::rshift16(40'(t_s) * 40'(t_s));
		hp[0] <= patan_pkg::C_A11;
		ht[0] <= t_s;
		hf[0] <= f_t;
	end

	for (genvar h = 0; h < 5; h++) begin : g_horner
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv[h+1] <= 1'b0;
			end else begin
				hv[h+1] <= hv[h];
			end
		end
		always_ff @(posedge clk) begin
			hp[h+1] <= patan_pkg::rshift16(40'(hp[h]) * 40'(hs[h])) + coef[h];
			ht[h+1] <= ht[h];
			hf[h+1] <= hf[h];
		end
		// The square is carried only as far as the last coefficient step.
		if (h < 4) begin : g_sq
			always_ff @(posedge clk) begin
				hs[h+1] <= hs[h];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv[6] <= 1'b0;
		end else begin
			hv[6] <= hv[5];
		end
	end
	always_ff @(posedge clk) begin
		hp[6] <= patan_pkg::rshift16(40'(ht[5]) * 40'(hp[5]));
		hf[6] <= hf[5];
	end

	// Quadrant correction.
	logic signed [21:0] res_c;
	logic signed [19:0] res_s;
	logic               zero_s;
	always_comb begin
		res_c = 22'(hp[6]);
		if (hf[6].swap) begin
			res_c = (hf[6].neg ? -22'(patan_pkg::HALF_PI_Q16) : 22'(patan_pkg::HALF_PI_Q16))
				- 22'(hp[6]);
		end
		if (hf[6].xneg) begin
			res_c = res_c + (hf[6].yneg ? -22'(patan_pkg::PI_Q16) : 22'(patan_pkg::PI_Q16));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv[7] <= 1'b0;
		end else begin
			hv[7] <= hv[6];
		end
	end
	always_ff @(posedge clk) begin
		res_s  <= res_c[19:0];
		zero_s <= hf[6].zero;
	end

	// Final rounding to Q3.13 and clamp; res fits in 20 bits signed.
	logic signed [19:0] rnd_c;
	logic signed [17:0] ang_c;
	logic               v_o_q;
	logic signed [AW-1:0] ang_q;
	always_comb begin
		rnd_c = (res_s + 20'sd4) >>> 3;
		ang_c = 18'(rnd_c);
		if (ang_c > patan_pkg::ANGLE_MAX) ang_c = patan_pkg::ANGLE_MAX;
		if (ang_c < -patan_pkg::ANGLE_MAX) ang_c = -patan_pkg::ANGLE_MAX;
		if (zero_s) ang_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_q <= 1'b0;
		end else begin
			v_o_q <= hv[7];
		end
	end
	always_ff @(posedge clk) begin
		ang_q <= ang_c[AW-1:0];
	end

	assign busy  = 1'b0;
	assign done  = v_o_q;
	assign angle = ang_q;

endmodule

// ----- src/patan_checker.sv -----
//------------------------------------------------------------------------------
// patan_checker: port-level checks for the polynomial atan2 unit
// Watches busy, done and the angle range on the top-level ports.
//------------------------------------------------------------------------------
module patan_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic signed [patan_pkg::ANGLE_WIDTH-1:0] angle
);

	// The unit never holds requests off.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every result stays inside minus pi to pi.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle <= 16'sd25736 && angle >= -16'sd25736))
		else $error("angle out of range");

	// A done without a matching earlier request is invented.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 28))
		else $error("result without request");

	// Every accepted request yields its result.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##28 done)
		else $error("request without result");

endmodule

bind polynomial_atan2_unit patan_checker u_patan_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .angle(angle)
);
